[hw/rtl/gss1_pkg.sv]
// Shared types and constants for the gradient skill score (S1) block.
// Used by gss1_ctrl, gss1_dpath and gradient_skill_score_s1; no dependencies.

package gss1_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int ACC_BITS       = 40;
   localparam int QUO_BITS       = 16;
   localparam int DIV_BITS       = ACC_BITS + QUO_BITS;
   localparam int SCORE_BITS     = 16;
   localparam int WORST_BITS     = 8;
   localparam int SIZE_CSR_BITS  = 7;
   localparam int CSR_ADDR_BITS  = 2;
   localparam int CSR_DATA_BITS  = 8;
   localparam int TERM_BITS      = SAMPLE_BITS + 3;
   localparam int CNT_BITS       = $clog2(QUO_BITS);

   localparam int MAX_COLS_DEF   = 64;
   localparam int MAX_ROWS_DEF   = 64;

   localparam logic [SIZE_CSR_BITS-1:0] SIZE_RESET  = SIZE_CSR_BITS'(2);
   localparam logic [WORST_BITS-1:0]    WORST_RESET = WORST_BITS'(200);

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_ROWS  = 2'd0,
      CSR_COLS  = 2'd1,
      CSR_WORST = 2'd2
   } csr_addr_type;

   typedef enum logic [2:0] {
      ST_RUN,
      ST_FLUSH,
      ST_LOAD,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic use_left;
      logic use_up;
      logic div_load;
      logic div_step;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } stat_type;

   typedef struct packed {
      logic [TERM_BITS-1:0] dd;
      logic [TERM_BITS-1:0] mx;
   } term_type;

endpackage

[hw/rtl/gss1_dpath.sv]
// Datapath of the S1 score block: line buffer, gradient terms, accumulators,
// restoring divider and result register. Depends on gss1_pkg.

module gss1_dpath import gss1_pkg::*; #(
   parameter int MAX_COLS = MAX_COLS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cmd_type                       cmd,
   input  logic [$clog2(MAX_COLS)-1:0]   rd_addr,
   input  logic [$clog2(MAX_COLS)-1:0]   wr_addr,
   input  logic signed [SAMPLE_BITS-1:0] ref_sample,
   input  logic signed [SAMPLE_BITS-1:0] eval_sample,
   input  logic [WORST_BITS-1:0]         worst_score,
   output stat_type                      stat,
   output logic [SCORE_BITS-1:0]         score_q8,
   output logic                          divisor_was_zero
);

   function automatic term_type grad_term(logic signed [SAMPLE_BITS-1:0] a_new,
                                          logic signed [SAMPLE_BITS-1:0] a_old,
                                          logic signed [SAMPLE_BITS-1:0] b_new,
                                          logic signed [SAMPLE_BITS-1:0] b_old);
      logic signed [SAMPLE_BITS:0]   ga;
      logic signed [SAMPLE_BITS:0]   gb;
      logic signed [SAMPLE_BITS+1:0] gd;
      logic [SAMPLE_BITS:0]          ma;
      logic [SAMPLE_BITS:0]          mb;
      logic [SAMPLE_BITS+1:0]        md;
      term_type                      t;
      ga = {a_new[SAMPLE_BITS-1], a_new} - {a_old[SAMPLE_BITS-1], a_old};
      gb = {b_new[SAMPLE_BITS-1], b_new} - {b_old[SAMPLE_BITS-1], b_old};
      gd = {ga[SAMPLE_BITS], ga} - {gb[SAMPLE_BITS], gb};
      ma = ga[SAMPLE_BITS] ? -ga : ga;
      mb = gb[SAMPLE_BITS] ? -gb : gb;
      md = gd[SAMPLE_BITS+1] ? -gd : gd;
      t.dd = TERM_BITS'(md);
      t.mx = (ma > mb) ? TERM_BITS'(ma) : TERM_BITS'(mb);
      return t;
   endfunction

   logic [2*SAMPLE_BITS-1:0]        line_mem [MAX_COLS];
   logic [2*SAMPLE_BITS-1:0]        line_rd_ff;
   logic signed [SAMPLE_BITS-1:0]   up_ref;
   logic signed [SAMPLE_BITS-1:0]   up_eval;
   logic signed [SAMPLE_BITS-1:0]   ref_left_ff, ref_left_in;
   logic signed [SAMPLE_BITS-1:0]   eval_left_ff, eval_left_in;

   term_type                        h_term;
   term_type                        v_term;
   logic [TERM_BITS-1:0]            term_dd_ff, term_dd_in;
   logic [TERM_BITS-1:0]            term_mx_ff, term_mx_in;
   logic                            term_vld_ff, term_vld_in;

   logic [ACC_BITS-1:0]             dvd_sum_ff, dvd_sum_in;
   logic [ACC_BITS-1:0]             dvs_sum_ff, dvs_sum_in;

   logic [DIV_BITS-1:0]             num_ff, num_in;
   logic [DIV_BITS-1:0]             dsh_ff, dsh_in;
   logic [DIV_BITS-1:0]             dvd_wide;
   logic [QUO_BITS-1:0]             quo_ff, quo_in;
   logic [CNT_BITS-1:0]             cnt_ff, cnt_in;
   logic                            zero_ff, zero_in;

   logic [SCORE_BITS-1:0]           score_ff, score_in;
   logic                            was_zero_ff, was_zero_in;

   // line buffer: write current column, prefetch the next one
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         line_mem[wr_addr] <= {eval_sample, ref_sample};
      end
      line_rd_ff <= line_mem[rd_addr];
   end

   assign up_ref  = line_rd_ff[SAMPLE_BITS-1:0];
   assign up_eval = line_rd_ff[2*SAMPLE_BITS-1:SAMPLE_BITS];

   always_comb begin
      h_term = cmd.use_left ? grad_term(ref_sample, ref_left_ff, eval_sample, eval_left_ff)
                            : '0;
      v_term = cmd.use_up ? grad_term(ref_sample, up_ref, eval_sample, up_eval) : '0;
      term_dd_in   = h_term.dd + v_term.dd;
      term_mx_in   = h_term.mx + v_term.mx;
      term_vld_in  = cmd.accept;
      ref_left_in  = cmd.accept ? ref_sample  : ref_left_ff;
      eval_left_in = cmd.accept ? eval_sample : eval_left_ff;

      dvd_sum_in = dvd_sum_ff;
      dvs_sum_in = dvs_sum_ff;
      if (cmd.div_load) begin
         dvd_sum_in = '0;
         dvs_sum_in = '0;
      end else if (term_vld_ff) begin
         dvd_sum_in = dvd_sum_ff + ACC_BITS'(term_dd_ff);
         dvs_sum_in = dvs_sum_ff + ACC_BITS'(term_mx_ff);
      end

      // 25600 = 2^14 + 2^13 + 2^10
      dvd_wide = DIV_BITS'(dvd_sum_ff);
      num_in  = num_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      zero_in = zero_ff;
      if (cmd.div_load) begin
         num_in  = (dvd_wide << 14) + (dvd_wide << 13) + (dvd_wide << 10);
         dsh_in  = DIV_BITS'(dvs_sum_ff) << (QUO_BITS - 1);
         quo_in  = '0;
         cnt_in  = CNT_BITS'(QUO_BITS - 1);
         zero_in = (dvs_sum_ff == '0);
      end else if (cmd.div_step) begin
         if (num_ff >= dsh_ff) begin
            num_in = num_ff - dsh_ff;
            quo_in = {quo_ff[QUO_BITS-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[QUO_BITS-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - CNT_BITS'(1);
      end

      score_in    = score_ff;
      was_zero_in = was_zero_ff;
      if (cmd.rsp_load) begin
         score_in    = zero_ff ? {worst_score, 8'h00} : quo_ff;
         was_zero_in = zero_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_vld_ff  <= 1'b0;
         dvd_sum_ff   <= '0;
         dvs_sum_ff   <= '0;
         ref_left_ff  <= '0;
         eval_left_ff <= '0;
         cnt_ff       <= '0;
      end else begin
         term_vld_ff  <= term_vld_in;
         dvd_sum_ff   <= dvd_sum_in;
         dvs_sum_ff   <= dvs_sum_in;
         ref_left_ff  <= ref_left_in;
         eval_left_ff <= eval_left_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      term_dd_ff  <= term_dd_in;
      term_mx_ff  <= term_mx_in;
      num_ff      <= num_in;
      dsh_ff      <= dsh_in;
      quo_ff      <= quo_in;
      zero_ff     <= zero_in;
      score_ff    <= score_in;
      was_zero_ff <= was_zero_in;
   end

   assign stat.div_last     = (cnt_ff == '0);
   assign score_q8          = score_ff;
   assign divisor_was_zero  = was_zero_ff;

endmodule

[hw/rtl/gss1_ctrl.sv]
// Controller of the S1 score block: grid position counters, request and
// result handshakes, divide sequencing. Depends on gss1_pkg.

module gss1_ctrl import gss1_pkg::*; #(
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int MAX_ROWS = MAX_ROWS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [SIZE_CSR_BITS-1:0]      cfg_rows,
   input  logic [SIZE_CSR_BITS-1:0]      cfg_cols,
   input  stat_type                      stat,
   output cmd_type                       cmd,
   output logic [$clog2(MAX_COLS)-1:0]   rd_addr,
   output logic [$clog2(MAX_COLS)-1:0]   wr_addr
);

   localparam int COL_W = $clog2(MAX_COLS);
   localparam int ROW_W = $clog2(MAX_ROWS);
   localparam int CSZ_W = $clog2(MAX_COLS + 1);
   localparam int RSZ_W = $clog2(MAX_ROWS + 1);

   state_type          state_ff, state_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic               rsp_vld_ff, rsp_vld_in;

   logic [CSZ_W-1:0]   n_cols;
   logic [RSZ_W-1:0]   n_rows;
   logic [CSZ_W-1:0]   col_p1;
   logic [RSZ_W-1:0]   row_p1;
   logic               col_end;
   logic               row_end;
   logic               accept;

   always_comb begin
      if (cfg_cols < SIZE_CSR_BITS'(2)) begin
         n_cols = CSZ_W'(2);
      end else if (32'(cfg_cols) > 32'(MAX_COLS)) begin
         n_cols = CSZ_W'(MAX_COLS);
      end else begin
         n_cols = CSZ_W'(cfg_cols);
      end
      if (cfg_rows < SIZE_CSR_BITS'(2)) begin
         n_rows = RSZ_W'(2);
      end else if (32'(cfg_rows) > 32'(MAX_ROWS)) begin
         n_rows = RSZ_W'(MAX_ROWS);
      end else begin
         n_rows = RSZ_W'(cfg_rows);
      end
      col_p1  = CSZ_W'(col_ff) + CSZ_W'(1);
      row_p1  = RSZ_W'(row_ff) + RSZ_W'(1);
      col_end = (col_p1 >= n_cols);
      row_end = (row_p1 >= n_rows);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_RUN;
         col_ff     <= '0;
         row_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      accept       = 1'b0;
      cmd.use_left = (col_ff != '0);
      cmd.use_up   = (row_ff != '0);
      case (state_ff)
         ST_RUN: begin
            req_tready = 1'b1;
            accept     = req_tvalid;
            if (accept && col_end && row_end) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
      cmd.accept = accept;

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         col_in = col_end ? '0 : COL_W'(col_p1);
         if (col_end) begin
            row_in = row_end ? '0 : ROW_W'(row_p1);
         end
      end
      rsp_vld_in = cmd.rsp_load | (rsp_vld_ff & ~rsp_tready);
   end

   assign rd_addr    = col_in;
   assign wr_addr    = col_ff;
   assign rsp_tvalid = rsp_vld_ff;

   a_rsp_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_vld_ff || rsp_tready))
      else $error("result loaded over an untaken result");

   a_grid_end: assert property (@(posedge clock) disable iff (reset)
      (accept && col_end && row_end) |=> (state_ff == ST_FLUSH))
      else $error("last request of a grid did not start the score");

   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> ##(QUO_BITS + 1) (state_ff == ST_DONE))
      else $error("divide sequence length wrong");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (32'(col_ff) < 32'(MAX_COLS)) && (32'(row_ff) < 32'(MAX_ROWS)))
      else $error("grid position out of range");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result raised outside the hand-off state");

endmodule

[hw/rtl/gradient_skill_score_s1.sv]
// Top level of the S1 gradient skill score block: configuration registers,
// controller and datapath. Depends on gss1_pkg, gss1_ctrl and gss1_dpath.

// One request (a reference and an evaluated sample of the same grid point,
// row-major) is taken per clock. After the last request of a grid the block
// holds req_tready low while it adds the final gradient terms, forms the
// scaled dividend, runs the one-bit-per-cycle restoring divider that yields
// the Q8 score, and hands the score to the result register. The hand-off
// cycle stretches for as long as the score of the previous grid still waits
// on rsp_tready. The result register is separate, so requests of the next
// grid flow while a score waits on rsp_tready. Previous-row samples sit in a
// MAX_COLS-entry line buffer memory. n_rows and n_cols in gss1_ctrl are
// clamped to 2..MAX_ROWS and 2..MAX_COLS.

module gradient_skill_score_s1 import gss1_pkg::*; #(
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int MAX_ROWS = MAX_ROWS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [2*SAMPLE_BITS-1:0]   req_tdata,   // ref_sample, eval_sample
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [SCORE_BITS-1:0]      rsp_tdata,   // score_q8
   output logic                       rsp_tuser,   // divisor_was_zero
   input  logic                       csr_wr_en,
   input  logic [CSR_ADDR_BITS-1:0]   csr_addr,
   input  logic [CSR_DATA_BITS-1:0]   csr_wdata
);

   logic [SIZE_CSR_BITS-1:0]          rows_ff;
   logic [SIZE_CSR_BITS-1:0]          cols_ff;
   logic [WORST_BITS-1:0]             worst_ff;
   cmd_type                           cmd;
   stat_type                          stat;
   logic [$clog2(MAX_COLS)-1:0]       rd_addr;
   logic [$clog2(MAX_COLS)-1:0]       wr_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= SIZE_RESET;
         cols_ff  <= SIZE_RESET;
         worst_ff <= WORST_RESET;
      end else if (csr_wr_en) begin
         case (csr_addr_type'(csr_addr))
            CSR_ROWS:  rows_ff  <= csr_wdata[SIZE_CSR_BITS-1:0];
            CSR_COLS:  cols_ff  <= csr_wdata[SIZE_CSR_BITS-1:0];
            CSR_WORST: worst_ff <= csr_wdata[WORST_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   gss1_ctrl #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cfg_rows   (rows_ff),
      .cfg_cols   (cols_ff),
      .stat       (stat),
      .cmd        (cmd),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr)
   );

   gss1_dpath #(
      .MAX_COLS (MAX_COLS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .rd_addr          (rd_addr),
      .wr_addr          (wr_addr),
      .ref_sample       (req_tdata[SAMPLE_BITS-1:0]),
      .eval_sample      (req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .worst_score      (worst_ff),
      .stat             (stat),
      .score_q8         (rsp_tdata),
      .divisor_was_zero (rsp_tuser)
   );

endmodule

[tb/tb.sv]
// Self-checking testbench for gradient_skill_score_s1: streams grids of sample
// pairs and scores each grid with a local S1 predictor. Needs gss1_pkg and the RTL.
`timescale 1ns / 1ps

module tb import gss1_pkg::*; ();

   localparam int unsigned PCT_Q8   = 100 * 256;
   localparam int SETTLE_CYCLES     = 25;
   localparam int END_CYCLES        = 40;
   localparam int RANDOM_ITEMS      = 900;
   localparam int HOLD_CYCLES       = 300;
   localparam int MAX_REPORTS       = 100;

   typedef struct {
      logic [SCORE_BITS-1:0] score;
      logic                  zero_div;
   } s1_score_type;

   typedef enum int {
      FIELD_NOISE,
      FIELD_SMOOTH,
      FIELD_SAME,
      FIELD_FLAT,
      FIELD_EXTREME
   } field_kind_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [2*SAMPLE_BITS-1:0] req_tdata = '0;   // ref_sample, eval_sample
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [SCORE_BITS-1:0]    rsp_tdata;        // score_q8
   logic                     rsp_tuser;        // divisor_was_zero
   logic                     csr_wr_en = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   gradient_skill_score_s1 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   initial begin
      #25ms;
      $display("simulation failed");
      $finish;
   end

   // configuration copy and predictor state
   logic [SIZE_CSR_BITS-1:0] rows_cfg  = SIZE_RESET;
   logic [SIZE_CSR_BITS-1:0] cols_cfg  = SIZE_RESET;
   logic [WORST_BITS-1:0]    worst_cfg = WORST_RESET;

   logic signed [SAMPLE_BITS-1:0] ref_row  [MAX_COLS_DEF];
   logic signed [SAMPLE_BITS-1:0] eval_row [MAX_COLS_DEF];
   logic signed [SAMPLE_BITS-1:0] ref_prev  = '0;
   logic signed [SAMPLE_BITS-1:0] eval_prev = '0;
   int                            col_pos = 0;
   int                            row_pos = 0;
   logic [ACC_BITS-1:0]           dividend_acc = '0;
   logic [ACC_BITS-1:0]           divisor_acc  = '0;

   s1_score_type score_q[$];
   int           err_count = 0;
   bit           idle_on = 1'b0;
   int           rsp_hold_cycles = 0;
   int           rsp_stall_left = 0;

   function automatic int fit_size(logic [SIZE_CSR_BITS-1:0] v, int hi);
      if (v < 2) return 2;
      if (v > hi) return hi;
      return int'(v);
   endfunction

   function automatic int grid_len();
      return fit_size(rows_cfg, MAX_ROWS_DEF) * fit_size(cols_cfg, MAX_COLS_DEF);
   endfunction

   function automatic int magnitude(int v);
      return v < 0 ? -v : v;
   endfunction

   function automatic void add_gradient(int r_new, int r_old, int e_new, int e_old);
      int gr;
      int ge;
      int ar;
      int ae;
      gr = r_new - r_old;
      ge = e_new - e_old;
      ar = magnitude(gr);
      ae = magnitude(ge);
      dividend_acc = dividend_acc + ACC_BITS'(magnitude(gr - ge));
      divisor_acc  = divisor_acc + ACC_BITS'(ar > ae ? ar : ae);
   endfunction

   function automatic void score_sample(logic [2*SAMPLE_BITS-1:0] d);
      logic signed [SAMPLE_BITS-1:0] x;
      logic signed [SAMPLE_BITS-1:0] y;
      logic [63:0]                   scaled;
      s1_score_type                  want;
      int                            nc;
      int                            nr;
      x  = d[SAMPLE_BITS-1:0];
      y  = d[2*SAMPLE_BITS-1:SAMPLE_BITS];
      nc = fit_size(cols_cfg, MAX_COLS_DEF);
      nr = fit_size(rows_cfg, MAX_ROWS_DEF);
      if (col_pos > 0) add_gradient(x, ref_prev, y, eval_prev);
      if (row_pos > 0) add_gradient(x, ref_row[col_pos], y, eval_row[col_pos]);
      ref_row[col_pos]  = x;
      eval_row[col_pos] = y;
      ref_prev  = x;
      eval_prev = y;
      if (col_pos + 1 < nc) begin
         col_pos++;
         return;
      end
      col_pos = 0;
      if (row_pos + 1 < nr) begin
         row_pos++;
         return;
      end
      row_pos = 0;
      if (divisor_acc != '0) begin
         scaled = (64'(dividend_acc) * 64'(PCT_Q8)) / 64'(divisor_acc);
         want.score    = scaled[SCORE_BITS-1:0];
         want.zero_div = 1'b0;
      end else begin
         want.score    = {worst_cfg, 8'h00};
         want.zero_div = 1'b1;
      end
      score_q.push_back(want);
      dividend_acc = '0;
      divisor_acc  = '0;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      if (err_count < MAX_REPORTS)
         $display("ERROR at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
      err_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) score_sample(req_tdata);
   end

   always @(posedge clock) begin
      s1_score_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (score_q.size() == 0) begin
            report_mismatch("score with none pending", rsp_tdata, -1);
         end else begin
            want = score_q.pop_front();
            if (rsp_tdata !== want.score)
               report_mismatch("score_q8", rsp_tdata, want.score);
            if (rsp_tuser !== want.zero_div)
               report_mismatch("divisor_was_zero", rsp_tuser, want.zero_div);
         end
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   // receiver: random stalls, plus a long hold when a test asks for one
   always @(posedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_stall_left  = rsp_hold_cycles;
         rsp_hold_cycles = 0;
      end else if (rsp_stall_left == 0 && idle_on && $urandom_range(0, 3) == 0) begin
         rsp_stall_left = gap_len();
      end
      if (rsp_stall_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic push_pair(logic [SAMPLE_BITS-1:0] r, logic [SAMPLE_BITS-1:0] e);
      int g;
      g = idle_on ? gap_len() : 0;
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {e, r};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (score_q.size() != 0);
   endtask

   task automatic write_csr(csr_addr_type a, logic [CSR_DATA_BITS-1:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_addr  <= a;
      csr_wdata <= v;
      case (a)
         CSR_ROWS:  rows_cfg  = v[SIZE_CSR_BITS-1:0];
         CSR_COLS:  cols_cfg  = v[SIZE_CSR_BITS-1:0];
         CSR_WORST: worst_cfg = v[WORST_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_grid(int rows, int cols, int worst);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_csr(CSR_ROWS, CSR_DATA_BITS'(rows));
      write_csr(CSR_COLS, CSR_DATA_BITS'(cols));
      write_csr(CSR_WORST, CSR_DATA_BITS'(worst));
   endtask

   function automatic logic [SAMPLE_BITS-1:0] extreme_val();
      case ($urandom_range(0, 3))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         default: return 16'hFFFF;
      endcase
   endfunction

   task automatic send_grid(field_kind_type kind);
      logic [SAMPLE_BITS-1:0] base_r;
      logic [SAMPLE_BITS-1:0] base_e;
      logic [SAMPLE_BITS-1:0] r;
      logic [SAMPLE_BITS-1:0] e;
      int                     n;
      base_r = SAMPLE_BITS'($urandom);
      base_e = SAMPLE_BITS'($urandom);
      n = grid_len();
      for (int i = 0; i < n; i++) begin
         case (kind)
            FIELD_SMOOTH: begin
               r = base_r + 16'($urandom_range(0, 255));
               e = r + 16'($urandom_range(0, 31)) - 16'd16;
            end
            FIELD_SAME: begin
               r = SAMPLE_BITS'($urandom);
               e = r;
            end
            FIELD_FLAT: begin
               r = base_r;
               e = base_e;
            end
            FIELD_EXTREME: begin
               r = extreme_val();
               e = extreme_val();
            end
            default: begin
               r = SAMPLE_BITS'($urandom);
               e = SAMPLE_BITS'($urandom);
            end
         endcase
         push_pair(r, e);
      end
   endtask

   task automatic test_extreme_samples();
      push_pair(16'h8000, 16'h7FFF);
      push_pair(16'h7FFF, 16'h8000);
      push_pair(16'h7FFF, 16'h7FFF);
      push_pair(16'h8000, 16'h8000);
      repeat (4) push_pair(16'h8000, 16'h7FFF);
   endtask

   task automatic test_zero_divisor();
      set_grid(2, 2, 0);
      repeat (4) push_pair(16'h1234, 16'hFEDC);
      set_grid(2, 2, 255);
      repeat (4) push_pair(16'h7FFF, 16'h8000);
   endtask

   task automatic test_identical_and_opposite();
      set_grid(2, 2, 200);
      push_pair(16'h1234, 16'h1234);
      push_pair(16'hFFFB, 16'hFFFB);
      push_pair(16'h7FFF, 16'h7FFF);
      push_pair(16'h8000, 16'h8000);
      push_pair(16'h0064, 16'hFF9C);
      push_pair(16'hFED4, 16'h012C);
      push_pair(16'h0005, 16'hFFFB);
      push_pair(16'h0000, 16'h0000);
   endtask

   task automatic test_size_limits();
      idle_on = 1'b1;
      set_grid(0, 1, 17);
      send_grid(FIELD_NOISE);
      set_grid(2, 64, 200);
      send_grid(FIELD_SMOOTH);
      set_grid(64, 2, 200);
      send_grid(FIELD_NOISE);
      set_grid(127, 3, 9);
      send_grid(FIELD_SMOOTH);
      set_grid(2, 200, 1);
      send_grid(FIELD_EXTREME);
   endtask

   task automatic test_result_backpressure();
      set_grid(2, 2, 200);
      idle_on = 1'b0;
      rsp_hold_cycles = HOLD_CYCLES;
      repeat (8) send_grid(field_kind_type'($urandom_range(0, 4)));
      set_grid(3, 2, 200);
      idle_on = 1'b1;
      repeat (4) begin
         send_grid(FIELD_SMOOTH);
         drain();
      end
   endtask

   function automatic int pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 88) return $urandom_range(2, 8);
      if (r < 96) return $urandom_range(9, 20);
      if (r < 98) return $urandom_range(0, 1);
      return $urandom_range(64, 127);
   endfunction

   function automatic int pick_worst();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return 200;
         2:       return 255;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   task automatic test_random_grids();
      int sent;
      int rows;
      int cols;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         rows = pick_size();
         cols = pick_size();
         if (rows > 20 && cols > 20) cols = 2;
         set_grid(rows, cols, pick_worst());
         idle_on = ($urandom_range(0, 3) != 0);
         repeat ($urandom_range(1, 6)) begin
            send_grid(field_kind_type'($urandom_range(0, 4)));
            sent += grid_len();
            if ($urandom_range(0, 7) == 0) drain();
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_extreme_samples();
      test_zero_divisor();
      test_identical_and_opposite();
      test_size_limits();
      test_result_backpressure();
      test_random_grids();
      drain();
      repeat (END_CYCLES) @(posedge clock);
      if (err_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

[sim.f]
hw/rtl/gss1_pkg.sv
hw/rtl/gss1_dpath.sv
hw/rtl/gss1_ctrl.sv
hw/rtl/gradient_skill_score_s1.sv
tb/tb.sv
